@@ rtl/core/hex_ascii_frame_decoder_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the hex ASCII frame decoder
// Concurrent checks clocked on the rising edge, held off while reset is low.
// ----------------------------------------------------------------------------
`ifndef HEX_ASCII_FRAME_DECODER_ASSERT_SVH
`define HEX_ASCII_FRAME_DECODER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define HAFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HAFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/hafd_pkg.sv @@
// ----------------------------------------------------------------------------
// hafd_pkg
// Shared constants, types and decode functions of the hex ASCII frame decoder.
// ----------------------------------------------------------------------------
package hafd_pkg;

    localparam int BUFFER_CHARS = 4096;
    localparam int CNT_W        = $clog2(BUFFER_CHARS);
    localparam int BYTE_W       = CNT_W - 1;
    localparam int IDX_W        = 11;
    localparam int LEN_W        = 16;
    localparam int CMP_W        = CNT_W + LEN_W;
    localparam int WIDE_W       = CNT_W + IDX_W;

    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(BUFFER_CHARS - 1);

    localparam logic [7:0] DELIM_RESET = 8'd35;
    localparam logic [7:0] CHAR_0      = 8'h30;
    localparam logic [7:0] CHAR_9      = 8'h39;
    localparam logic [7:0] CHAR_UA     = 8'h41;
    localparam logic [7:0] CHAR_UF     = 8'h46;
    localparam logic [7:0] CHAR_LA     = 8'h61;
    localparam logic [7:0] CHAR_LF     = 8'h66;
    localparam logic [7:0] DIGIT_TEN   = 8'd10;

    typedef enum logic [1:0] {
        ST_ACCEPT   = 2'd0,
        ST_ODD      = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_SHORT    = 2'd3
    } t_status;

    typedef struct packed {
        logic       is_delim;
        logic [3:0] nibble;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_link;

    typedef struct packed {
        logic             is_end;
        logic [7:0]       data_byte;
        logic [IDX_W-1:0] byte_index;
        t_status          frame_status;
    } t_result;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= CHAR_0 && c <= CHAR_9) begin
            d = c - CHAR_0;
        end else if (c >= CHAR_UA && c <= CHAR_UF) begin
            d = c - CHAR_UA + DIGIT_TEN;
        end else if (c >= CHAR_LA && c <= CHAR_LF) begin
            d = c - CHAR_LA + DIGIT_TEN;
        end
        return d[3:0];
    endfunction

    function automatic logic [IDX_W-1:0] to_index(input logic [BYTE_W-1:0] b);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(b);
        return w[IDX_W-1:0];
    endfunction

endpackage

@@ rtl/core/hex_ascii_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// hex_ascii_frame_decoder
// Decodes hex ASCII characters into bytes and ends frames on a delimiter
// with a verdict on character count and the little-endian length field.
//
//   Channel  | Handshake                   | Payload
//   ---------+-----------------------------+------------------------------
//   input    | push / full                 | i_char_in
//   result   | empty / pop                 | o_is_end, o_data_byte,
//            |                             | o_byte_index, o_frame_status
//   config   | i_cfg_valid / o_cfg_ready   | i_cfg_data (delimiter)
//
// One character per cycle sustained while full stays low. A result passes
// through the request queue and then the result queue, both registered,
// before it is on the result ports. Both queues hold two entries, so a
// stalled result side backs up into full only after four pending requests.
// Reset is synchronous and sets the delimiter to '#' and clears the frame count.
// ----------------------------------------------------------------------------
module hex_ascii_frame_decoder (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [7:0]                 i_char_in,
    output logic                       empty,
    input  logic                       pop,
    output logic                       o_is_end,
    output logic [7:0]                 o_data_byte,
    output logic [hafd_pkg::IDX_W-1:0] o_byte_index,
    output logic [1:0]                 o_frame_status,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [7:0]                 i_cfg_data
);
    import hafd_pkg::*;

    t_cmd_link cmd;
    logic      cmd_take;

    hafd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_char_in   (i_char_in),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    hafd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_cmd_take     (cmd_take),
        .empty          (empty),
        .pop            (pop),
        .o_is_end       (o_is_end),
        .o_data_byte    (o_data_byte),
        .o_byte_index   (o_byte_index),
        .o_frame_status (o_frame_status)
    );

endmodule

@@ rtl/core/hafd_front.sv @@
// ----------------------------------------------------------------------------
// hafd_front
// Accepts characters, tags delimiters, decodes hex digits and queues the
// classified requests for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module hafd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          i_char_in,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data,
    output hafd_pkg::t_cmd_link o_cmd,
    input  logic                i_cmd_take
);
    import hafd_pkg::*;

    logic [7:0] r_delim;
    t_cmd       r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    logic       accept;
    logic       take;
    t_cmd       new_cmd;

    assign o_cfg_ready = 1'b1;
    assign full        = (r_cnt == 2'd2);
    assign accept      = push && !full;
    assign take        = i_cmd_take && (r_cnt != 2'd0);

    always_comb begin
        new_cmd.is_delim = (i_char_in == r_delim);
        new_cmd.nibble   = hex_value(i_char_in);
    end

    assign o_cmd.valid = (r_cnt != 2'd0);
    assign o_cmd.cmd   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= DELIM_RESET;
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_cnt   <= 2'd0;
        end else begin
            if (i_cfg_valid) begin
                r_delim <= i_cfg_data;
            end
            if (accept) begin
                r_wr <= ~r_wr;
            end
            if (take) begin
                r_rd <= ~r_rd;
            end
            if (accept && !take) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (take && !accept) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr] <= new_cmd;
        end
    end

endmodule

@@ rtl/core/hafd_back.sv @@
// ----------------------------------------------------------------------------
// hafd_back
// Carries out classified requests: pairs digits into bytes, tracks the frame
// count and length field, builds the verdict and queues results.
// ----------------------------------------------------------------------------
`include "hex_ascii_frame_decoder_assert.svh"

module hafd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hafd_pkg::t_cmd_link           i_cmd,
    output logic                          o_cmd_take,
    output logic                          empty,
    input  logic                          pop,
    output logic                          o_is_end,
    output logic [7:0]                    o_data_byte,
    output logic [hafd_pkg::IDX_W-1:0]    o_byte_index,
    output logic [1:0]                    o_frame_status
);
    import hafd_pkg::*;

    logic [CNT_W-1:0] r_char_count, n_char_count;
    logic [3:0]       r_high_nibble, n_high_nibble;
    logic [LEN_W-1:0] r_length, n_length;

    t_result          r_out_q [2];
    logic             r_out_wr;
    logic             r_out_rd;
    logic [1:0]       r_out_cnt;

    logic             out_full;
    logic             out_pop;
    logic             produce;
    logic             exec;
    logic             out_push;
    logic             stored;
    logic [BYTE_W-1:0] bytes;
    logic [CMP_W-1:0] bytes_wide;
    logic [CMP_W-1:0] len_wide;
    logic [7:0]       pair;
    t_result          res;
    t_result          head;

    assign out_full = (r_out_cnt == 2'd2);
    assign out_pop  = pop && (r_out_cnt != 2'd0);
    assign stored   = (r_char_count < CNT_LIMIT);
    assign bytes    = r_char_count[CNT_W-1:1];
    assign bytes_wide = CMP_W'(bytes);
    assign len_wide   = CMP_W'(r_length);
    assign pair       = {r_high_nibble, i_cmd.cmd.nibble};

    // a delimiter always yields a verdict; a stored second digit yields a byte
    assign produce    = i_cmd.cmd.is_delim || (stored && r_char_count[0]);
    assign exec       = i_cmd.valid && (!produce || !out_full);
    assign out_push   = exec && produce;
    assign o_cmd_take = exec;

    always_comb begin
        n_char_count  = r_char_count;
        n_high_nibble = r_high_nibble;
        n_length      = r_length;
        res.is_end       = 1'b0;
        res.data_byte    = pair;
        res.byte_index   = to_index(bytes);
        res.frame_status = ST_ACCEPT;
        if (i_cmd.cmd.is_delim) begin
            res.is_end    = 1'b1;
            res.data_byte = 8'd0;
            priority if (r_char_count[0]) begin
                res.frame_status = ST_ODD;
            end else if (bytes_wide < CMP_W'(2)) begin
                res.frame_status = ST_SHORT;
            end else if (len_wide != bytes_wide - CMP_W'(2)) begin
                res.frame_status = ST_MISMATCH;
            end else begin
                res.frame_status = ST_ACCEPT;
            end
            if (exec) begin
                n_char_count  = '0;
                n_high_nibble = 4'd0;
                n_length      = '0;
            end
        end else if (exec && stored) begin
            n_char_count = r_char_count + CNT_W'(1);
            if (!r_char_count[0]) begin
                n_high_nibble = i_cmd.cmd.nibble;
            end else if (bytes == BYTE_W'(0)) begin
                n_length = {r_length[15:8], pair};
            end else if (bytes == BYTE_W'(1)) begin
                n_length = {pair, r_length[7:0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_count  <= '0;
            r_high_nibble <= 4'd0;
            r_length      <= '0;
            r_out_wr      <= 1'b0;
            r_out_rd      <= 1'b0;
            r_out_cnt     <= 2'd0;
        end else begin
            r_char_count  <= n_char_count;
            r_high_nibble <= n_high_nibble;
            r_length      <= n_length;
            if (out_push) begin
                r_out_wr <= ~r_out_wr;
            end
            if (out_pop) begin
                r_out_rd <= ~r_out_rd;
            end
            if (out_push && !out_pop) begin
                r_out_cnt <= r_out_cnt + 2'd1;
            end else if (out_pop && !out_push) begin
                r_out_cnt <= r_out_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_push) begin
            r_out_q[r_out_wr] <= res;
        end
    end

    assign head           = r_out_q[r_out_rd];
    assign empty          = (r_out_cnt == 2'd0);
    assign o_is_end       = head.is_end;
    assign o_data_byte    = head.data_byte;
    assign o_byte_index   = head.byte_index;
    assign o_frame_status = head.frame_status;

    `HAFD_ASSERT_NOW(a_count_in_range, i_clk, i_rst_n, 1'b1, r_char_count <= CNT_LIMIT, "char count above buffer limit")
    `HAFD_ASSERT_NEXT(a_delim_clears, i_clk, i_rst_n, exec && i_cmd.cmd.is_delim, r_char_count == '0 && r_length == '0, "frame state not cleared after verdict")
    `HAFD_ASSERT_NEXT(a_result_queued, i_clk, i_rst_n, out_push, !empty, "result lost on push")
    `HAFD_ASSERT_NOW(a_no_overfill, i_clk, i_rst_n, out_full, !out_push, "result pushed into full queue")

endmodule

@@ tb/sv/hex_ascii_frame_decoder_test.sv @@
// ----------------------------------------------------------------------------
// hex_ascii_frame_decoder_test
// Feeds characters into the decoder and checks every decoded byte and every
// end-of-frame verdict against an in-bench prediction. A short table of
// directed characters comes first, then random frames under several
// delimiter settings. Push and pop idle in random bursts, and the result
// side holds off once in the first random phase.
// ----------------------------------------------------------------------------
module hex_ascii_frame_decoder_test;

    import hafd_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        t_result    res;
    } t_dir_row;

    localparam int N_DIRECTED   = 25;
    localparam int HOLD_CYCLES  = 150;
    localparam int PHASE_CHARS  = 250;
    localparam int N_PHASES     = 5;
    localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(BUFFER_CHARS - 1);

    // delimiter settings per random phase; the fourth one is drawn at random
    localparam logic [7:0] DELIM_SET [N_PHASES] = '{8'h00, 8'hFF, 8'h0A, 8'h00, 8'h23};

    localparam t_dir_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{"#",   1'b1, '{1'b1, 8'h00, 11'd0, ST_SHORT}},
        '{"0",   1'b0, '0},
        '{"2",   1'b0, '0},
        '{"0",   1'b0, '0},
        '{"0",   1'b0, '0},
        '{"F",   1'b0, '0},
        '{"f",   1'b1, '{1'b0, 8'hFF, 11'd2, ST_ACCEPT}},
        '{"A",   1'b0, '0},
        '{"9",   1'b0, '0},
        '{"#",   1'b1, '{1'b1, 8'h00, 11'd4, ST_ACCEPT}},
        '{"1",   1'b0, '0},
        '{"#",   1'b1, '{1'b1, 8'h00, 11'd0, ST_ODD}},
        '{"0",   1'b0, '0},
        '{"5",   1'b0, '0},
        '{"0",   1'b0, '0},
        '{"0",   1'b0, '0},
        '{"#",   1'b1, '{1'b1, 8'h00, 11'd2, ST_MISMATCH}},
        '{8'hFF, 1'b0, '0},
        '{8'h80, 1'b1, '{1'b0, 8'h00, 11'd0, ST_ACCEPT}},
        '{"a",   1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{"#",   1'b1, '{1'b1, 8'h00, 11'd2, ST_MISMATCH}},
        '{"4",   1'b0, '0},
        '{"2",   1'b0, '0},
        '{"#",   1'b1, '{1'b1, 8'h00, 11'd1, ST_SHORT}}
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             push;
    logic             full;
    logic [7:0]       i_char_in;
    logic             empty;
    logic             pop;
    logic             o_is_end;
    logic [7:0]       o_data_byte;
    logic [IDX_W-1:0] o_byte_index;
    logic [1:0]       o_frame_status;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [7:0]       i_cfg_data;

    // decoder state as the bench sees it
    logic [7:0]       delim_model;
    logic [CNT_W-1:0] stored_chars;
    logic [3:0]       upper_nibble;
    logic [15:0]      frame_length;

    t_result pending_results [$];
    int      mismatch_cnt;
    int      chars_sent;
    bit      quiet;
    bit      hold_req;
    bit      rx_hold;

    hex_ascii_frame_decoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_char_in      (i_char_in),
        .empty          (empty),
        .pop            (pop),
        .o_is_end       (o_is_end),
        .o_data_byte    (o_data_byte),
        .o_byte_index   (o_byte_index),
        .o_frame_status (o_frame_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("hex_ascii_frame_decoder: mismatch");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        mismatch_cnt++;
    endtask

    function automatic logic [3:0] digit_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= "0" && c <= "9") begin
            d = c - "0";
        end else if (c >= "A" && c <= "F") begin
            d = c - "A" + 8'd10;
        end else if (c >= "a" && c <= "f") begin
            d = c - "a" + 8'd10;
        end
        return d[3:0];
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) begin
            return "0" + 8'(v);
        end else if ($urandom_range(0, 1) == 0) begin
            return "A" + 8'(v) - 8'd10;
        end
        return "a" + 8'(v) - 8'd10;
    endfunction

    // Advance the decoder state by one character; return 1 when it yields a result.
    function automatic bit decode_char(input logic [7:0] c, output t_result r);
        logic [10:0] nbytes;
        logic [7:0]  b;
        r = '0;
        nbytes = stored_chars[CNT_W-1:1];
        if (c == delim_model) begin
            r.is_end     = 1'b1;
            r.byte_index = nbytes;
            if (stored_chars[0]) begin
                r.frame_status = ST_ODD;
            end else if (nbytes < 11'd2) begin
                r.frame_status = ST_SHORT;
            end else if (frame_length != 16'(nbytes) - 16'd2) begin
                r.frame_status = ST_MISMATCH;
            end else begin
                r.frame_status = ST_ACCEPT;
            end
            stored_chars = '0;
            upper_nibble = '0;
            frame_length = '0;
            return 1'b1;
        end
        // drop characters once the buffer is full
        if (stored_chars >= LAST_SLOT) begin
            return 1'b0;
        end
        if (!stored_chars[0]) begin
            upper_nibble = digit_value(c);
            stored_chars++;
            return 1'b0;
        end
        b = {upper_nibble, digit_value(c)};
        if (nbytes == 11'd0) begin
            frame_length[7:0] = b;
        end else if (nbytes == 11'd1) begin
            frame_length[15:8] = b;
        end
        stored_chars++;
        r.data_byte  = b;
        r.byte_index = nbytes;
        return 1'b1;
    endfunction

    // Offer one character, wait for the request to be taken, then maybe idle.
    task automatic send_char(input logic [7:0] c, input bit fixed, input t_result fixed_res);
        t_result r;
        @(negedge i_clk);
        push      <= 1'b1;
        i_char_in <= c;
        do @(posedge i_clk); while (full);
        if (decode_char(c, r)) begin
            pending_results.push_back(fixed ? fixed_res : r);
        end
        chars_sent++;
        if (!quiet && $urandom_range(0, 15) == 0) begin
            repeat ($urandom_range(1, 11)) begin
                @(negedge i_clk);
                push <= 1'b0;
            end
        end
    endtask

    // Drop push and wait until every expected result is out, plus some slack.
    task automatic settle(input int slack);
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (slack) @(posedge i_clk);
    endtask

    initial begin
        rx_hold = 1'b0;
        wait (hold_req);
        @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    initial begin
        int      stall_left;
        t_result want;
        stall_left = 0;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold) begin
                pop <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0) begin
                    stall_left = $urandom_range(1, 11);
                end
            end
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result end=%0d byte=%02h idx=%0d st=%0d",
                                            o_is_end, o_data_byte, o_byte_index,
                                            o_frame_status));
                end else begin
                    want = pending_results.pop_front();
                    if (o_is_end !== want.is_end) begin
                        flag_mismatch($sformatf("is_end %0d, want %0d",
                                                o_is_end, want.is_end));
                    end
                    if (o_data_byte !== want.data_byte) begin
                        flag_mismatch($sformatf("data_byte %02h, want %02h",
                                                o_data_byte, want.data_byte));
                    end
                    if (o_byte_index !== want.byte_index) begin
                        flag_mismatch($sformatf("byte_index %0d, want %0d",
                                                o_byte_index, want.byte_index));
                    end
                    if (o_frame_status !== want.frame_status) begin
                        flag_mismatch($sformatf("frame_status %0d, want %0d",
                                                o_frame_status, want.frame_status));
                    end
                end
            end
        end
    end

    initial begin
        int         phase_start;
        int         kind;
        int         nbytes;
        bit         cut_odd;
        logic [7:0] body [64];
        logic [7:0] lo;
        logic [7:0] new_delim;

        push         = 1'b0;
        i_char_in    = 8'h00;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = 8'h00;
        i_rst_n      = 1'b0;
        quiet        = 1'b0;
        hold_req     = 1'b0;
        mismatch_cnt = 0;
        chars_sent   = 0;
        delim_model  = DELIM_RESET;
        stored_chars = '0;
        upper_nibble = '0;
        frame_length = '0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_char(DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
        end

        for (int phase = 0; phase < N_PHASES; phase++) begin
            settle(4);
            new_delim = (phase == 3) ? 8'($urandom_range(0, 255)) : DELIM_SET[phase];
            @(negedge i_clk);
            i_cfg_valid <= 1'b1;
            i_cfg_data  <= new_delim;
            do @(posedge i_clk); while (!o_cfg_ready);
            delim_model = new_delim;
            @(negedge i_clk);
            i_cfg_valid <= 1'b0;

            if (phase == 0) begin
                hold_req = 1'b1;
            end
            if (phase == N_PHASES - 1) begin
                quiet = 1'b1;
            end

            phase_start = chars_sent;
            while (chars_sent - phase_start < PHASE_CHARS) begin
                kind = $urandom_range(0, 99);
                if (kind < 8) begin
                    repeat ($urandom_range(1, 6)) begin
                        send_char(8'($urandom_range(0, 255)), 1'b0, '0);
                    end
                end else begin
                    nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                         : $urandom_range(0, 8);
                    for (int k = 0; k < nbytes; k++) begin
                        body[k] = 8'($urandom_range(0, 255));
                    end
                    // mostly a length field that matches the byte count less the two length bytes
                    if (nbytes >= 2 && $urandom_range(0, 4) != 0) begin
                        body[0] = 8'(nbytes - 2);
                        body[1] = 8'h00;
                    end
                    cut_odd = ($urandom_range(0, 11) == 0);
                    for (int k = 0; k < nbytes; k++) begin
                        lo = hex_char(body[k][3:0]);
                        if ($urandom_range(0, 39) == 0) begin
                            lo = 8'($urandom_range(0, 255));
                        end
                        send_char(hex_char(body[k][7:4]), 1'b0, '0);
                        if (!(cut_odd && k == nbytes - 1)) begin
                            send_char(lo, 1'b0, '0);
                        end
                    end
                    // now and then leave the frame open so it runs into the next one
                    if ($urandom_range(0, 19) != 0) begin
                        send_char(delim_model, 1'b0, '0);
                    end
                end
            end
        end

        settle(12);
        if (mismatch_cnt == 0 && pending_results.size() == 0) begin
            $display("hex_ascii_frame_decoder: match");
        end else begin
            $display("hex_ascii_frame_decoder: mismatch");
        end
        $finish;
    end

endmodule
